@@ rtl/ssi_pkg.sv @@
// Shared types, constants and lookup functions for the sunrise sample interval block.
// No dependencies; every other file in this folder imports it.
package ssi_pkg;

  typedef logic [31:0] epoch_t;
  typedef logic [16:0] interval_t;
  typedef logic [15:0] delay_t;
  typedef logic [15:0] days_t;
  typedef logic [16:0] sod_t;
  typedef logic [17:0] doe_t;
  typedef logic [8:0]  yoe_t;
  typedef logic [8:0]  doy_t;
  typedef logic [3:0]  month_t;
  typedef logic [4:0]  mday_t;
  typedef logic [18:0] tenths_t;
  typedef logic [23:0] num_t;

  localparam int unsigned PADDR_W   = 3;
  localparam logic        REG_DELAY = 1'b0;
  localparam delay_t      DELAY_RESET = 16'd7200;

  localparam logic [16:0] DAY_SEC = 17'd86400;
  localparam logic [19:0] DAYS_TO_EPOCH = 20'd719468;
  localparam logic [19:0] ERA4_START = 20'd584388;
  localparam logic [19:0] ERA5_START = 20'd730485;

  localparam logic [25:0] RECIP_675  = 26'(((64'd1 << 35) + 64'd674) / 64'd675);
  localparam logic [18:0] RECIP_1460 = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam logic [18:0] RECIP_365  = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam logic [23:0] RECIP_155  = 24'(((64'd1 << 31) + 64'd154) / 64'd155);

  localparam month_t MONTH_LAST = 4'd11;

  function automatic tenths_t sunrise_tenths(input month_t mon);
    tenths_t r;
    case (mon)
      4'd0:    r = 19'd316800;
      4'd1:    r = 19'd301212;
      4'd2:    r = 19'd270000;
      4'd3:    r = 19'd228600;
      4'd4:    r = 19'd191412;
      4'd5:    r = 19'd166212;
      4'd6:    r = 19'd164988;
      4'd7:    r = 19'd186588;
      4'd8:    r = 19'd215388;
      4'd9:    r = 19'd243000;
      4'd10:   r = 19'd274212;
      4'd11:   r = 19'd303588;
      default: r = 19'd0;
    endcase
    return r;
  endfunction

  // First day of each month in a March-based year, counted from March 1st.
  function automatic doy_t month_start(input month_t mp);
    doy_t r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/ssi_if.sv @@
// Valid/ready channel interfaces for time requests and interval results.
// Depends on ssi_pkg for the payload types.
interface ssi_req_if;
  import ssi_pkg::*;
  logic   valid;
  logic   ready;
  epoch_t epoch_seconds;
  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface ssi_rsp_if;
  import ssi_pkg::*;
  logic      valid;
  logic      ready;
  interval_t seconds_to_target;
  modport source (output valid, output seconds_to_target, input ready);
  modport sink   (input valid, input seconds_to_target, output ready);
endinterface

@@ rtl/sunrise_sample_interval.sv @@
// Top level of the sunrise sample interval block: ten-stage calendar and interpolation pipeline.
// Depends on ssi_pkg and the channel interfaces in ssi_if.sv.
//
// For each request carrying a UTC epoch time the block returns the seconds until the next daily
// target, which is the sunrise interpolated from a monthly table plus the programmable delay,
// saturated to one day. It takes one request per clock while the pipeline is not stalled, and
// passes it through the ten register stages that split the calendar decomposition and the
// reciprocal multiplications. Backpressure on the result side stalls the pipeline only once it
// is full. The delay register sits at byte address 0 and should be written while idle.
module sunrise_sample_interval (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ssi_req_if.sink                        req_i,
  ssi_rsp_if.source                      rsp_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ssi_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import ssi_pkg::*;

  localparam int unsigned NS = 10;

  delay_t delay_q;
  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;

  days_t     days_s0_q;
  epoch_t    now_s0_q;
  sod_t      sod_s1_q, sod_s2_q, sod_s3_q, sod_s4_q, sod_s5_q, sod_s6_q, sod_s7_q, sod_s8_q;
  doe_t      doe_s1_q, doe_s2_q, doe_s3_q;
  doe_t      tyr_s2_q;
  yoe_t      yoe_s3_q;
  doy_t      doy_s4_q;
  month_t    mon_s5_q;
  mday_t     mday_s5_q;
  num_t      num_s6_q;
  logic [46:0] quot_s7_q;
  sod_t      tgt_s8_q;
  interval_t out_q;

  logic [50:0] days_prod;
  days_t       days_d;
  logic [32:0] day_base;
  sod_t        sod_d;
  logic [19:0] zday;
  doe_t        doe_d;
  logic [36:0] q1460_prod;
  logic [2:0]  c36524;
  logic        c146096;
  doe_t        tyr_d;
  logic [36:0] yoe_prod;
  yoe_t        yoe_d;
  logic [1:0]  c100;
  doe_t        yr_base;
  doy_t        doy_d;
  month_t      mp;
  mday_t       mday_d;
  month_t      mon_d;
  tenths_t     sr_a, sr_b;
  logic signed [19:0] sr_dlt;
  logic signed [25:0] sr_step;
  logic [23:0] sr_base;
  num_t        num_d;
  logic [46:0] quot_d;
  sod_t        tgt_d;
  logic [17:0] diff_wrap, diff_fwd;
  interval_t   out_d;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DELAY) ? {16'd0, delay_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DELAY_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_DELAY)) begin
      delay_q <= pwdata[15:0];
    end
  end

  always_comb begin
    en[NS-1] = !vld_q[NS-1] || rsp_o.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign req_i.ready = en[0];
  assign rsp_o.valid = vld_q[NS-1];
  assign rsp_o.seconds_to_target = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= req_i.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_comb begin
    days_prod = 51'(req_i.epoch_seconds[31:7]) * 51'(RECIP_675);
    days_d    = days_prod[50:35];

    day_base = 33'(days_s0_q) * 33'(DAY_SEC);
    sod_d    = 17'(now_s0_q - day_base[31:0]);
    zday     = 20'(days_s0_q) + DAYS_TO_EPOCH;
    doe_d    = (zday >= ERA5_START) ? 18'(zday - ERA5_START) : 18'(zday - ERA4_START);

    q1460_prod = 37'(doe_s1_q) * 37'(RECIP_1460);
    c36524  = 3'(doe_s1_q >= 18'd36524) + 3'(doe_s1_q >= 18'd73048)
            + 3'(doe_s1_q >= 18'd109572) + 3'(doe_s1_q >= 18'd146096);
    c146096 = (doe_s1_q >= 18'd146096);
    tyr_d   = doe_s1_q - 18'(q1460_prod[36:29]) + 18'(c36524) - 18'(c146096);

    yoe_prod = 37'(tyr_s2_q) * 37'(RECIP_365);
    yoe_d    = yoe_prod[35:27];

    c100    = 2'(yoe_s3_q >= 9'd100) + 2'(yoe_s3_q >= 9'd200) + 2'(yoe_s3_q >= 9'd300);
    yr_base = 18'(yoe_s3_q) * 18'd365 + 18'(yoe_s3_q[8:2]) - 18'(c100);
    doy_d   = 9'(doe_s3_q - yr_base);

    mp = '0;
    for (int k = 1; k <= 11; k++) begin
      mp = mp + 4'(doy_s4_q >= month_start(4'(k)));
    end
    mday_d = 5'(doy_s4_q - month_start(mp) + 9'd1);
    mon_d  = (mp < 4'd10) ? mp + 4'd2 : mp - 4'd10;

    sr_a    = sunrise_tenths(mon_s5_q);
    sr_b    = sunrise_tenths((mon_s5_q == MONTH_LAST) ? 4'd0 : mon_s5_q + 4'd1);
    sr_dlt  = $signed({1'b0, sr_b}) - $signed({1'b0, sr_a});
    sr_step = 26'(sr_dlt) * $signed({1'b0, mday_s5_q});
    sr_base = {sr_a, 5'd0} - 24'(sr_a);
    num_d   = 24'($signed({2'b00, sr_base}) + sr_step);

    quot_d = 47'(num_s6_q[23:1]) * 47'(RECIP_155);

    tgt_d = 17'(quot_s7_q[46:31]) + 17'(delay_q);

    diff_wrap = 18'(tgt_s8_q) + 18'(DAY_SEC) - 18'(sod_s8_q);
    diff_fwd  = 18'(tgt_s8_q) - 18'(sod_s8_q);
    if (tgt_s8_q <= sod_s8_q) begin
      out_d = 17'(diff_wrap);
    end else if (diff_fwd > 18'(DAY_SEC)) begin
      out_d = DAY_SEC;
    end else begin
      out_d = 17'(diff_fwd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      days_s0_q <= days_d;
      now_s0_q  <= req_i.epoch_seconds;
    end
    if (en[1]) begin
      sod_s1_q <= sod_d;
      doe_s1_q <= doe_d;
    end
    if (en[2]) begin
      sod_s2_q <= sod_s1_q;
      doe_s2_q <= doe_s1_q;
      tyr_s2_q <= tyr_d;
    end
    if (en[3]) begin
      sod_s3_q <= sod_s2_q;
      doe_s3_q <= doe_s2_q;
      yoe_s3_q <= yoe_d;
    end
    if (en[4]) begin
      sod_s4_q <= sod_s3_q;
      doy_s4_q <= doy_d;
    end
    if (en[5]) begin
      sod_s5_q  <= sod_s4_q;
      mon_s5_q  <= mon_d;
      mday_s5_q <= mday_d;
    end
    if (en[6]) begin
      sod_s6_q <= sod_s5_q;
      num_s6_q <= num_d;
    end
    if (en[7]) begin
      sod_s7_q  <= sod_s6_q;
      quot_s7_q <= quot_d;
    end
    if (en[8]) begin
      sod_s8_q <= sod_s7_q;
      tgt_s8_q <= tgt_d;
    end
    if (en[9]) begin
      out_q <= out_d;
    end
  end

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (out_q >= 17'd1) && (out_q <= DAY_SEC))
    else $error("interval result out of range");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[5] |-> (mday_s5_q >= 5'd1) && (mday_s5_q <= 5'd31) && (mon_s5_q <= MONTH_LAST))
    else $error("calendar decomposition out of range");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[0] |-> req_i.ready)
    else $error("empty first stage refused a request");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> vld_q[0])
    else $error("accepted request did not enter the pipeline");

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for sunrise_sample_interval: random and directed epoch times are
// streamed through the request channel and every interval is compared with a local calendar model.
// Depends on ssi_pkg, the channel interfaces in ssi_if.sv and the block's top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ssi_pkg::*;

  localparam logic [PADDR_W-1:0] DELAY_ADDR = PADDR_W'(4 * int'(REG_DELAY));
  localparam longint unsigned SECS_PER_DAY = 86400;
  localparam longint unsigned SUNRISE_TABLE [12] = '{
    316800, 301212, 270000, 228600, 191412, 166212,
    164988, 186588, 215388, 243000, 274212, 303588
  };
  localparam int PHASES = 7;
  localparam int ITEMS_PER_PHASE = 262;
  localparam int MAX_PRINTED = 100;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ssi_req_if req_if ();
  ssi_rsp_if rsp_if ();

  logic         drv_valid = 1'b0;
  epoch_t       drv_epoch = '0;
  logic         rsp_ready = 1'b1;
  logic         apb_sel = 1'b0;
  logic         apb_enable = 1'b0;
  logic         apb_write = 1'b0;
  logic [PADDR_W-1:0] apb_addr = '0;
  logic [31:0]  apb_wdata = '0;
  logic [31:0]  prdata_w;
  logic         pready_w;

  epoch_t    pending_epochs[$];
  interval_t expected_intervals[$];
  delay_t    delay_setting = DELAY_RESET;
  int        send_pct = 0;
  int        recv_pct = 0;
  int        send_gap = 0;
  int        stall_left = 0;
  int        error_count = 0;

  assign req_if.valid         = drv_valid;
  assign req_if.epoch_seconds = drv_epoch;
  assign rsp_if.ready         = rsp_ready;

  sunrise_sample_interval i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (apb_sel),
    .penable (apb_enable),
    .pwrite  (apb_write),
    .paddr   (apb_addr),
    .pwdata  (apb_wdata),
    .prdata  (prdata_w),
    .pready  (pready_w)
  );

  always #5 clk_i = ~clk_i;

  function automatic interval_t interval_after(input epoch_t now_s, input delay_t delay);
    longint unsigned now_v, days, z, era, doe, yoe, doy, mp, mday, mon;
    longint unsigned rise_a, rise_b, sunrise, target, diff;
    now_v = now_s;
    days = now_v / SECS_PER_DAY;
    z = days + 719468;
    era = z / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp = (5 * doy + 2) / 153;
    mday = doy - (153 * mp + 2) / 5 + 1;
    mon = (mp < 10) ? mp + 2 : mp - 10;
    if (mday > 31) mday = 31;
    rise_a = SUNRISE_TABLE[mon];
    rise_b = SUNRISE_TABLE[(mon + 1) % 12];
    sunrise = (rise_b * mday + rise_a * (31 - mday)) / 310;
    target = days * SECS_PER_DAY + sunrise + longint'(delay);
    if (target <= now_v) target += SECS_PER_DAY;
    diff = target - now_v;
    if (diff > SECS_PER_DAY) diff = SECS_PER_DAY;
    return interval_t'(diff);
  endfunction

  function automatic int draw_gap(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // Time at which the day's target is reached, as seen from midnight of that day.
  function automatic longint unsigned target_of_day(input longint unsigned day);
    longint unsigned midnight;
    midnight = day * SECS_PER_DAY;
    return midnight + longint'(interval_after(epoch_t'(midnight), delay_setting));
  endfunction

  function automatic epoch_t draw_epoch();
    longint unsigned day, t;
    int kind;
    kind = $urandom_range(0, 9);
    day = $urandom_range(0, 49710);
    if (kind < 4) return $urandom;
    if (kind < 8) begin
      t = target_of_day(day) + $urandom_range(0, 6) - 3;
    end else if (kind == 8) begin
      t = day * SECS_PER_DAY + $urandom_range(0, 3);
    end else begin
      t = day * SECS_PER_DAY + SECS_PER_DAY - 1 - $urandom_range(0, 3);
    end
    if (t > 64'hFFFF_FFFF) return $urandom;
    return epoch_t'(t);
  endfunction

  task automatic report_mismatch(input string what);
    if (error_count < MAX_PRINTED) $display("tb: mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  task automatic write_delay(input delay_t value);
    logic [31:0] word;
    word = {16'($urandom), value};
    @(posedge clk_i);
    apb_sel <= 1'b1;
    apb_enable <= 1'b0;
    apb_write <= 1'b1;
    apb_addr <= DELAY_ADDR;
    apb_wdata <= word;
    @(posedge clk_i);
    apb_enable <= 1'b1;
    @(posedge clk_i);
    while (!pready_w) @(posedge clk_i);
    delay_setting = value;
    apb_write <= 1'b0;
    apb_enable <= 1'b0;
    @(posedge clk_i);
    apb_enable <= 1'b1;
    @(posedge clk_i);
    while (!pready_w) @(posedge clk_i);
    if (prdata_w !== {16'h0, value}) begin
      report_mismatch($sformatf("delay readback %h, wrote %h", prdata_w, value));
    end
    apb_sel <= 1'b0;
    apb_enable <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_epochs.size() != 0 || expected_intervals.size() != 0) @(negedge clk_i);
    repeat (14) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!drv_valid || req_if.ready) begin
        if (drv_valid) pending_epochs.delete(0);
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          drv_valid <= 1'b0;
        end else if (pending_epochs.size() != 0) begin
          drv_valid <= 1'b1;
          drv_epoch <= pending_epochs[0];
          send_gap <= draw_gap(send_pct);
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
        stall_left <= draw_gap(recv_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) begin
      expected_intervals.push_back(interval_after(req_if.epoch_seconds, delay_setting));
    end
  end

  always @(posedge clk_i) begin
    interval_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_intervals.size() == 0) begin
        report_mismatch($sformatf("interval %0d with no request pending",
                                  rsp_if.seconds_to_target));
      end else begin
        want = expected_intervals.pop_front();
        if (rsp_if.seconds_to_target !== want) begin
          report_mismatch($sformatf("seconds_to_target %0d, expected %0d",
                                    rsp_if.seconds_to_target, want));
        end
      end
    end
  end

  initial begin
    longint unsigned corner_days [4];
    longint unsigned t;
    delay_t phase_delay [PHASES];
    int phase_send [PHASES];
    int phase_recv [PHASES];

    corner_days = '{0, 10957, 19782, 11016};
    phase_delay = '{16'd0, 16'd43200, 16'hFFFF, 16'($urandom_range(0, 43200)), 16'd1,
                    16'($urandom_range(0, 43200)), DELAY_RESET};
    phase_send = '{30, 0, 50, 20, 10, 40, 25};
    phase_recv = '{20, 0, 10, 50, 30, 25, 40};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pct = 20;
    recv_pct = 20;
    pending_epochs.push_back(32'h0000_0000);
    pending_epochs.push_back(32'hFFFF_FFFF);
    pending_epochs.push_back(32'h7FFF_FFFF);
    pending_epochs.push_back(32'h8000_0000);
    pending_epochs.push_back(32'd946684799);
    pending_epochs.push_back(32'd946684800);
    pending_epochs.push_back(32'd951782400);
    pending_epochs.push_back(32'd951868800);
    pending_epochs.push_back(32'd1675123200);
    pending_epochs.push_back(32'd1709164800);
    pending_epochs.push_back(32'd4294944000);
    pending_epochs.push_back(32'd946771199);
    // Times just before, exactly at and just after the day's target.
    foreach (corner_days[k]) begin
      t = target_of_day(corner_days[k]);
      pending_epochs.push_back(epoch_t'(t - 1));
      pending_epochs.push_back(epoch_t'(t));
      pending_epochs.push_back(epoch_t'(t + 1));
    end
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      write_delay(phase_delay[p]);
      send_pct = phase_send[p];
      recv_pct = phase_recv[p];
      t = target_of_day(corner_days[p % 4]);
      pending_epochs.push_back(epoch_t'(t));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) pending_epochs.push_back(draw_epoch());
      wait_drained();
    end

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule
